>>> rtl/core/bwg_pkg.sv
// bwg_pkg: shared constants, register codes and the direction table for the
// backprojection weight generator. No dependencies.
package bwg_pkg;

	localparam int ANGLE_COUNT = 256;
	localparam int TRIG_BITS   = 16;

	localparam int TRIG_FRAC = TRIG_BITS - 1;
	localparam int T_FRAC    = 16 + TRIG_FRAC;
	localparam int ANG_W     = $clog2(ANGLE_COUNT);
	localparam int DIR_DEPTH = 1 << ANG_W;

	// field and register widths
	localparam int COL_W    = 12;
	localparam int ROW_W    = 12;
	localparam int ANGIN_W  = 10;
	localparam int PIX_W    = 13;
	localparam int OFS_W    = 12;
	localparam int SCALE_W  = 24;
	localparam int CFG_W    = 24;
	localparam int CFGIDX_W = 3;
	localparam int HALF_W   = OFS_W - 1;
	localparam int MROW_W   = 24;
	localparam int MCOL_W   = 22;
	localparam int WGT_W    = 16;

	// datapath widths
	localparam int PX_W     = COL_W + 1 + SCALE_W;
	localparam int CX_W     = PX_W + 1;
	localparam int PROD_W   = TRIG_BITS + CX_W;
	localparam int T_W      = PROD_W + 1;
	localparam int K_W      = T_W - T_FRAC;
	localparam int BIN_W    = K_W + 1;
	localparam int WPROD_W  = WGT_W + T_FRAC;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] PREFACTOR_FULL =
		(PI_Q30 + (64'(ANGLE_COUNT) << 13)) / (64'(ANGLE_COUNT) << 14);
	localparam logic [WGT_W-1:0] PREFACTOR = PREFACTOR_FULL[WGT_W-1:0];
	localparam logic [ANGIN_W:0] ANGLE_COUNT_V = (ANGIN_W + 1)'(ANGLE_COUNT);

	typedef enum logic [CFGIDX_W-1:0] {
		REG_PIXELS_X     = 3'd0,
		REG_PIXELS_Y     = 3'd1,
		REG_OFFSET_COUNT = 3'd2,
		REG_SCALE_X      = 3'd3,
		REG_SCALE_Y      = 3'd4
	} cfg_reg_t;

	// one entry: {cos, sin}, each Q1.TRIG_FRAC two's complement
	typedef logic [DIR_DEPTH-1:0][2*TRIG_BITS-1:0] dir_table_t;

	// Q2.30 series value to Q1.TRIG_FRAC, round half up, clamp to [0, 1)
	function automatic logic [TRIG_BITS-1:0] to_trig(longint v);
		logic [63:0] r;
		logic [63:0] top;
		top = (64'd1 << TRIG_FRAC) - 64'd1;
		if (v < 0)
			v = 0;
		r = (64'(v) + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
		if (r > top)
			r = top;
		return r[TRIG_BITS-1:0];
	endfunction

	// taylor series of cos/sin, worked out at elaboration
	function automatic dir_table_t build_dir_table();
		dir_table_t tbl;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] aa;
		longint cq;
		longint sq;
		longint v;
		logic neg;
		logic [TRIG_BITS-1:0] c;
		logic [TRIG_BITS-1:0] s;
		tbl = '0;
		for (int a = 0; a < DIR_DEPTH; a++) begin
			if (a < ANGLE_COUNT) begin
				aa = 64'(a);
				neg = 1'b0;
				if (2 * a > ANGLE_COUNT) begin
					aa = 64'(ANGLE_COUNT - a);
					neg = 1'b1;
				end
				x = aa * PI_Q30 / 64'(ANGLE_COUNT);
				term = 64'd1 << 30;
				cq = 0;
				sq = 0;
				for (int k = 0; k < 20; k++) begin
					v = (((k >> 1) & 1) == 0) ? longint'(term) : -longint'(term);
					if ((k & 1) == 0)
						cq = cq + v;
					else
						sq = sq + v;
					term = ((term * x) >> 30) / 64'(k + 1);
				end
				c = to_trig(cq);
				s = to_trig(sq);
				if (neg)
					c = -c;
				tbl[a] = {c, s};
			end
		end
		return tbl;
	endfunction

	localparam dir_table_t DIR_TABLE = build_dir_table();

endpackage

>>> rtl/core/bwg_dir_rom.sv
// bwg_dir_rom: registered lookup of cos/sin for an angle number.
// Depends on bwg_pkg (DIR_TABLE, widths).
module bwg_dir_rom (
	input  logic                                clk,
	input  logic                                en,
	input  logic [bwg_pkg::ANG_W-1:0]           angle,
	output logic signed [bwg_pkg::TRIG_BITS-1:0] cos_s1,
	output logic signed [bwg_pkg::TRIG_BITS-1:0] sin_s1
);
	import bwg_pkg::*;

	always_ff @(posedge clk) begin
		if (en)
			{cos_s1, sin_s1} <= DIR_TABLE[angle];
	end

endmodule

>>> rtl/core/backprojection_weight_gen.sv
// backprojection_weight_gen: six-stage pipeline giving matrix indices and
// linear-interpolation weights per (pixel, angle) request.
// Depends on bwg_pkg and bwg_dir_rom.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+---------------------------------------------
//   pix      | pix_valid / pix_stall | pixel_col, pixel_row, angle_index
//   res      | res_valid / res_stall | matrix_row, matrix_col, weight_low, weight_high
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// One request enters per cycle while pix_stall is low.
// The depth is set by the table read, the two multiplier stages and the weight
// product. Requests with an out-of-range angle or bin leave a bubble instead.
// Reset clears all valid bits and loads the register reset values.
// A stall holds only the stages that are full up to the output; bubbles close.
module backprojection_weight_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  logic [bwg_pkg::COL_W-1:0]      pixel_col,
	input  logic [bwg_pkg::ROW_W-1:0]      pixel_row,
	input  logic [bwg_pkg::ANGIN_W-1:0]    angle_index,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [bwg_pkg::MROW_W-1:0]     matrix_row,
	output logic [bwg_pkg::MCOL_W-1:0]     matrix_col,
	output logic [bwg_pkg::WGT_W-1:0]      weight_low,
	output logic [bwg_pkg::WGT_W-1:0]      weight_high,
	input  logic                           cfg_write,
	input  logic [bwg_pkg::CFGIDX_W-1:0]   cfg_index,
	input  logic [bwg_pkg::CFG_W-1:0]      cfg_data
);
	import bwg_pkg::*;

	logic [PIX_W-1:0]   pixels_y_q;
	logic [OFS_W-1:0]   offset_count_q;
	logic [SCALE_W-1:0] scale_x_q;
	logic [SCALE_W-1:0] scale_y_q;
	logic [HALF_W-1:0]  half;
	logic [OFS_W-1:0]   ofs_m1;
	logic [HALF_W+15:0] half_sh;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [TRIG_BITS-1:0] cos_s1, sin_s1, cos_s2, sin_s2;
	logic [PX_W-1:0]     px_s1, py_s1;
	logic [MROW_W-1:0]   rowmul_s1, mrow_s2, mrow_s3, mrow_s4, mrow_s5, mrow_s6;
	logic [ROW_W-1:0]    row_s1;
	logic [MCOL_W-1:0]   angoff_s1, angoff_s2, angoff_s3, angoff_s4, angoff_s5;
	logic [MCOL_W-1:0]   mcol_s6;
	logic signed [CX_W-1:0]   cx_s2, cy_s2;
	logic signed [PROD_W-1:0] pc_s3, ps_s3;
	logic signed [T_W-1:0]    t_sum;
	logic signed [K_W-1:0]    k_s4;
	logic [T_FRAC-1:0]        frac_s4;
	logic signed [BIN_W-1:0]  bin_s5;
	logic [WPROD_W-1:0]       wprod_s5;
	logic [WPROD_W:0]         wsum;
	logic [WGT_W-1:0]         wh;
	logic [WGT_W-1:0]         wh_s6, wl_s6;
	logic                     ang_ok;
	logic                     bin_ok;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_y_q     <= PIX_W'(256);
			offset_count_q <= OFS_W'(255);
			scale_x_q      <= SCALE_W'(32640);
			scale_y_q      <= SCALE_W'(32640);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PIXELS_X:     ;  // grid width does not enter the results
				REG_PIXELS_Y:     pixels_y_q     <= cfg_data[PIX_W-1:0];
				REG_OFFSET_COUNT: offset_count_q <= cfg_data[OFS_W-1:0];
				REG_SCALE_X:      scale_x_q      <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:      scale_y_q      <= cfg_data[SCALE_W-1:0];
				default:          ;
			endcase
		end
	end

	assign ofs_m1  = offset_count_q - OFS_W'(1);
	assign half    = (offset_count_q == '0) ? '0 : ofs_m1[OFS_W-1:1];
	assign half_sh = {half, 16'h0000};

	// a stage moves when it is empty or the next one moves
	assign en6 = !v6_s6 || !res_stall;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign pix_stall = !en1;

	assign ang_ok = {1'b0, angle_index} < ANGLE_COUNT_V;
	assign t_sum  = T_W'(pc_s3) + T_W'(ps_s3);
	assign bin_ok = !bin_s5[BIN_W-1] &&
		((BIN_W + 1)'(unsigned'(bin_s5)) + (BIN_W + 1)'(1) < (BIN_W + 1)'(offset_count_q));
	assign wsum = (WPROD_W + 1)'(wprod_s5) + ((WPROD_W + 1)'(1) << (T_FRAC - 1));
	assign wh   = wsum[T_FRAC +: WGT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= pix_valid && ang_ok;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) v6_s6 <= v5_s5 && bin_ok;
		end
	end

	bwg_dir_rom u_dir_rom (
		.clk    (clk),
		.en     (en1),
		.angle  (angle_index[ANG_W-1:0]),
		.cos_s1 (cos_s1),
		.sin_s1 (sin_s1)
	);

	always_ff @(posedge clk) begin
		// stage 1: table read, the coordinate scaling and the two index products
		if (en1) begin
			px_s1     <= PX_W'({pixel_col, 1'b1}) * PX_W'(scale_x_q);
			py_s1     <= PX_W'({pixel_row, 1'b1}) * PX_W'(scale_y_q);
			rowmul_s1 <= MROW_W'(pixel_col) * MROW_W'(pixels_y_q);
			row_s1    <= pixel_row;
			angoff_s1 <= MCOL_W'(angle_index) * MCOL_W'(offset_count_q);
		end
		// stage 2: center the coordinates on the detector
		if (en2) begin
			cx_s2     <= {1'b0, px_s1} - CX_W'(half_sh);
			cy_s2     <= {1'b0, py_s1} - CX_W'(half_sh);
			cos_s2    <= cos_s1;
			sin_s2    <= sin_s1;
			mrow_s2   <= rowmul_s1 + MROW_W'(row_s1);
			angoff_s2 <= angoff_s1;
		end
		// stage 3: project onto the direction
		if (en3) begin
			pc_s3     <= PROD_W'(cos_s2) * PROD_W'(cx_s2);
			ps_s3     <= PROD_W'(sin_s2) * PROD_W'(cy_s2);
			mrow_s3   <= mrow_s2;
			angoff_s3 <= angoff_s2;
		end
		// stage 4: floor and fraction
		if (en4) begin
			k_s4      <= t_sum[T_W-1:T_FRAC];
			frac_s4   <= t_sum[T_FRAC-1:0];
			mrow_s4   <= mrow_s3;
			angoff_s4 <= angoff_s3;
		end
		// stage 5: bin and weight product
		if (en5) begin
			bin_s5    <= BIN_W'(k_s4) + BIN_W'(half);
			wprod_s5  <= WPROD_W'(PREFACTOR) * WPROD_W'(frac_s4);
			mrow_s5   <= mrow_s4;
			angoff_s5 <= angoff_s4;
		end
		// stage 6: output register
		if (en6) begin
			mrow_s6 <= mrow_s5;
			mcol_s6 <= bin_s5[MCOL_W-1:0] + angoff_s5;
			wh_s6   <= wh;
			wl_s6   <= PREFACTOR - wh;
		end
	end

	assign res_valid   = v6_s6;
	assign matrix_row  = mrow_s6;
	assign matrix_col  = mcol_s6;
	assign weight_low  = wl_s6;
	assign weight_high = wh_s6;

endmodule

>>> rtl/core/bwg_checker.sv
// bwg_checker: port-level assertions for backprojection_weight_gen, bound
// to the top level below. Depends on bwg_pkg (PREFACTOR, widths).
module bwg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pix_valid,
	input logic                         pix_stall,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic [bwg_pkg::MROW_W-1:0]   matrix_row,
	input logic [bwg_pkg::MCOL_W-1:0]   matrix_col,
	input logic [bwg_pkg::WGT_W-1:0]    weight_low,
	input logic [bwg_pkg::WGT_W-1:0]    weight_high
);
	import bwg_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(matrix_row) &&
		$stable(matrix_col) && $stable(weight_low) && $stable(weight_high))
		else $error("stalled result changed");

	// the two weights always split the prefactor
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (WGT_W + 1)'(weight_low) + (WGT_W + 1)'(weight_high) ==
		(WGT_W + 1)'(PREFACTOR))
		else $error("weights do not sum to prefactor");

	// requests are only held back by a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("request stalled with free output");

	// no result right out of reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid after reset");

endmodule

bind backprojection_weight_gen bwg_checker u_bwg_checker (.*);
